>>> design/c2p_pkg.sv
// shared types and constants for the cartesian to polar converter
// no dependencies; used by every module of the block

package c2p_pkg;

	// normalized datapath widths
	localparam int NORM_TOP = 39;
	localparam int NORM_W = NORM_TOP + 1;
	localparam int SH_W = 6;
	localparam int CX_W = 44;
	localparam int Z_W = 32;

	// result word field widths
	localparam int MAG_W = 16;
	localparam int ANGLE_W = 17;
	localparam int QUAD_W = 3;

	// magnitude post scaling
	localparam logic [31:0] GAIN_Q32 = 32'h9B74EDA8;
	localparam int SUM_W = 60;
	localparam int MAG_MAX = 65535;

	// angle constants in units of pi/32768
	localparam int HALF_PI_OUT = 16384;
	localparam int PI_OUT = 32768;
	localparam int A_W = 15;

	// quadrant codes
	localparam logic [QUAD_W-1:0] QUAD_ORIGIN = 3'd0;
	localparam logic [QUAD_W-1:0] QUAD_1 = 3'd1;
	localparam logic [QUAD_W-1:0] QUAD_2 = 3'd2;
	localparam logic [QUAD_W-1:0] QUAD_3 = 3'd3;
	localparam logic [QUAD_W-1:0] QUAD_4 = 3'd4;

	// point class, decides how the final result is picked
	typedef enum logic [1:0] {
		KIND_ORIGIN,
		KIND_X_AXIS,
		KIND_Y_AXIS,
		KIND_GENERAL
	} kind_t;

	// side information that travels with each word
	typedef struct packed {
		logic [QUAD_W-1:0] quad;
		logic              x_neg;
		logic              y_neg;
		kind_t             kind;
		logic [SH_W-1:0]   sh;
		logic [MAG_W-1:0]  axis_mag;
	} side_t;

	// arctangent of 2^-idx in units of pi/2^31
	function automatic logic [31:0] atan_step(input int idx);
		case (idx)
			0:  return 32'd536870912;
			1:  return 32'd316933406;
			2:  return 32'd167458907;
			3:  return 32'd85004756;
			4:  return 32'd42667331;
			5:  return 32'd21354465;
			6:  return 32'd10679838;
			7:  return 32'd5340245;
			8:  return 32'd2670163;
			9:  return 32'd1335087;
			10: return 32'd667544;
			11: return 32'd333772;
			12: return 32'd166886;
			13: return 32'd83443;
			14: return 32'd41722;
			15: return 32'd20861;
			16: return 32'd10430;
			17: return 32'd5215;
			18: return 32'd2608;
			19: return 32'd1304;
			20: return 32'd652;
			21: return 32'd326;
			22: return 32'd163;
			23: return 32'd81;
			24: return 32'd41;
			25: return 32'd20;
			26: return 32'd10;
			27: return 32'd5;
			28: return 32'd3;
			29: return 32'd1;
			30: return 32'd1;
			default: return 32'd0;
		endcase
	endfunction

endpackage

>>> design/cartesian_to_polar.sv
// channel  | handshake            | payload
// ---------+----------------------+---------------------------------------
// point    | pt_valid / pt_ready  | x_coord, y_coord (COORD_WIDTH signed)
// result   | res_valid / res_ready| magnitude, angle, quadrant
//
// one word enters per cycle while no finished result is held; a result passes
// through three front end stages, one stage per cordic micro-rotation and
// three back end stages ending in the result register.
// the whole pipe advances together: a held result freezes every stage, so
// nothing is dropped or repeated, and empty stages move on whenever it is taken.
// reset clears the valid bits only; no clearing pass is needed.
// top level: depends on c2p_pkg, c2p_norm, c2p_cordic, c2p_post

module cartesian_to_polar #(
	parameter int COORD_WIDTH = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 pt_valid,
	output logic                                 pt_ready,
	input  logic signed [COORD_WIDTH-1:0]        x_coord,
	input  logic signed [COORD_WIDTH-1:0]        y_coord,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output logic [c2p_pkg::MAG_W-1:0]            magnitude,
	output logic signed [c2p_pkg::ANGLE_W-1:0]   angle,
	output logic [c2p_pkg::QUAD_W-1:0]           quadrant
);
	import c2p_pkg::*;

	logic                   adv;
	logic                   norm_valid;
	logic [NORM_W-1:0]      norm_cx;
	logic [NORM_W-1:0]      norm_cy;
	side_t                  norm_side;
	logic                   cordic_valid;
	logic signed [CX_W-1:0] cordic_cx;
	logic signed [Z_W-1:0]  cordic_z;
	side_t                  cordic_side;

	// pipe moves unless a finished word is waiting
	assign adv = !res_valid || res_ready;
	assign pt_ready = adv;

	c2p_norm #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.valid     (pt_valid),
		.x_coord   (x_coord),
		.y_coord   (y_coord),
		.norm_valid(norm_valid),
		.cx        (norm_cx),
		.cy        (norm_cy),
		.side      (norm_side)
	);

	c2p_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv),
		.valid       (norm_valid),
		.cx_in       (norm_cx),
		.cy_in       (norm_cy),
		.side_in     (norm_side),
		.cordic_valid(cordic_valid),
		.cx_out      (cordic_cx),
		.z_out       (cordic_z),
		.side_out    (cordic_side)
	);

	c2p_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.valid    (cordic_valid),
		.cx       (cordic_cx),
		.z        (cordic_z),
		.side     (cordic_side),
		.res_valid(res_valid),
		.magnitude(magnitude),
		.angle    (angle),
		.quadrant (quadrant)
	);

	// origin gives an all-zero word
	ap_origin: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && quadrant == QUAD_ORIGIN |-> magnitude == '0 && angle == '0)
		else $error("origin word with nonzero magnitude or angle");

	// first quadrant angle lies in [0, pi/2]
	ap_quad1: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && quadrant == QUAD_1 |-> angle >= 17'sd0 && angle <= 17'sd16384)
		else $error("first quadrant angle out of range");

	// fourth quadrant angle lies in [-pi/2, 0]
	ap_quad4: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && quadrant == QUAD_4 |-> angle <= 17'sd0 && angle >= -17'sd16384)
		else $error("fourth quadrant angle out of range");

endmodule

>>> design/c2p_norm.sv
// front end: fold to first quadrant, classify, normalize by binary shift search
// depends on c2p_pkg

module c2p_norm #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                valid,
	input  logic signed [COORD_WIDTH-1:0]       x_coord,
	input  logic signed [COORD_WIDTH-1:0]       y_coord,
	output logic                                norm_valid,
	output logic [c2p_pkg::NORM_W-1:0]          cx,
	output logic [c2p_pkg::NORM_W-1:0]          cy,
	output c2p_pkg::side_t                      side
);
	import c2p_pkg::*;

	localparam logic [COORD_WIDTH:0] MAG_LIM = (COORD_WIDTH + 1)'(MAG_MAX);

	logic [COORD_WIDTH-1:0] ax;
	logic [COORD_WIDTH-1:0] ay;
	logic [COORD_WIDTH-1:0] mx;
	logic [COORD_WIDTH-1:0] axis_src;
	logic                   x_pos;
	logic                   y_pos;
	side_t                  side_d;

	logic                   valid_s1;
	logic [COORD_WIDTH-1:0] ax_s1;
	logic [COORD_WIDTH-1:0] ay_s1;
	logic [COORD_WIDTH-1:0] mx_s1;
	side_t                  side_s1;

	logic [NORM_W-1:0]      m_a;
	logic [NORM_W-1:0]      a_a;
	logic [NORM_W-1:0]      b_a;
	logic [SH_W-1:0]        sh_a;
	side_t                  side_a;

	logic                   valid_s2;
	logic [NORM_W-1:0]      m_s2;
	logic [NORM_W-1:0]      a_s2;
	logic [NORM_W-1:0]      b_s2;
	side_t                  side_s2;

	logic [NORM_W-1:0]      m_b;
	logic [NORM_W-1:0]      a_b;
	logic [NORM_W-1:0]      b_b;
	logic [SH_W-1:0]        sh_b;
	side_t                  side_b;

	logic                   valid_s3;
	logic [NORM_W-1:0]      a_s3;
	logic [NORM_W-1:0]      b_s3;
	side_t                  side_s3;

	// absolute values, quadrant code and point class
	always_comb begin
		ax = x_coord[COORD_WIDTH-1] ? COORD_WIDTH'(-x_coord) : COORD_WIDTH'(x_coord);
		ay = y_coord[COORD_WIDTH-1] ? COORD_WIDTH'(-y_coord) : COORD_WIDTH'(y_coord);
		mx = (ax > ay) ? ax : ay;
		x_pos = !x_coord[COORD_WIDTH-1] && (x_coord != '0);
		y_pos = !y_coord[COORD_WIDTH-1] && (y_coord != '0);

		side_d = '0;
		side_d.x_neg = x_coord[COORD_WIDTH-1];
		side_d.y_neg = y_coord[COORD_WIDTH-1];
		if (x_pos) begin
			side_d.quad = side_d.y_neg ? QUAD_4 : QUAD_1;
		end else if (side_d.x_neg) begin
			side_d.quad = y_pos ? QUAD_2 : QUAD_3;
		end else begin
			side_d.quad = y_pos ? QUAD_2 : (side_d.y_neg ? QUAD_4 : QUAD_ORIGIN);
		end

		if (ax == '0 && ay == '0) begin
			side_d.kind = KIND_ORIGIN;
		end else if (ay == '0) begin
			side_d.kind = KIND_X_AXIS;
		end else if (ax == '0) begin
			side_d.kind = KIND_Y_AXIS;
		end else begin
			side_d.kind = KIND_GENERAL;
		end

		// on an axis the magnitude is the nonzero coordinate, saturated
		axis_src = (ay == '0) ? ax : ay;
		side_d.axis_mag = ({1'b0, axis_src} > MAG_LIM) ? '1 : MAG_W'(axis_src);
	end

	// valid bits for all front end stages, and the stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= ax;
			ay_s1 <= ay;
			mx_s1 <= mx;
			side_s1 <= side_d;
		end
	end

	// coarse shift search: steps of 32, 16 and 8
	always_comb begin
		int amt;
		m_a = NORM_W'(mx_s1);
		a_a = NORM_W'(ax_s1);
		b_a = NORM_W'(ay_s1);
		sh_a = '0;
		for (int k = 0; k < 3; k++) begin
			amt = 32 >> k;
			if ((m_a >> (NORM_W - amt)) == '0) begin
				m_a = m_a << amt;
				a_a = a_a << amt;
				b_a = b_a << amt;
				sh_a = sh_a + SH_W'(amt);
			end
		end
		side_a = side_s1;
		side_a.sh = sh_a;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s2 <= m_a;
			a_s2 <= a_a;
			b_s2 <= b_a;
			side_s2 <= side_a;
		end
	end

	// fine shift search: steps of 4, 2 and 1
	always_comb begin
		int amt;
		m_b = m_s2;
		a_b = a_s2;
		b_b = b_s2;
		sh_b = side_s2.sh;
		for (int k = 0; k < 3; k++) begin
			amt = 4 >> k;
			if ((m_b >> (NORM_W - amt)) == '0) begin
				m_b = m_b << amt;
				a_b = a_b << amt;
				b_b = b_b << amt;
				sh_b = sh_b + SH_W'(amt);
			end
		end
		side_b = side_s2;
		side_b.sh = sh_b;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3 <= a_b;
			b_s3 <= b_b;
			side_s3 <= side_b;
		end
	end

	assign norm_valid = valid_s3;
	assign cx = a_s3;
	assign cy = b_s3;
	assign side = side_s3;

endmodule

>>> design/c2p_cordic.sv
// unrolled cordic vectoring pipeline, one micro-rotation per register stage
// depends on c2p_pkg

module c2p_cordic #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              valid,
	input  logic [c2p_pkg::NORM_W-1:0]        cx_in,
	input  logic [c2p_pkg::NORM_W-1:0]        cy_in,
	input  c2p_pkg::side_t                    side_in,
	output logic                              cordic_valid,
	output logic signed [c2p_pkg::CX_W-1:0]   cx_out,
	output logic signed [c2p_pkg::Z_W-1:0]    z_out,
	output c2p_pkg::side_t                    side_out
);
	import c2p_pkg::*;

	logic                   valid_chain [CORDIC_STEPS+1];
	logic signed [CX_W-1:0] cx_chain    [CORDIC_STEPS+1];
	logic signed [CX_W-1:0] cy_chain    [CORDIC_STEPS+1];
	logic signed [Z_W-1:0]  z_chain     [CORDIC_STEPS+1];
	side_t                  side_chain  [CORDIC_STEPS+1];

	assign valid_chain[0] = valid;
	assign cx_chain[0] = $signed(CX_W'(cx_in));
	assign cy_chain[0] = $signed(CX_W'(cy_in));
	assign z_chain[0] = '0;
	assign side_chain[0] = side_in;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		localparam logic signed [Z_W-1:0] ATAN_I = $signed(Z_W'(atan_step(i)));

		logic signed [CX_W-1:0] dx;
		logic signed [CX_W-1:0] dy;
		logic signed [CX_W-1:0] cx_nx;
		logic signed [CX_W-1:0] cy_nx;
		logic signed [Z_W-1:0]  z_nx;

		logic                   valid_s;
		logic signed [CX_W-1:0] cx_s;
		logic signed [CX_W-1:0] cy_s;
		logic signed [Z_W-1:0]  z_s;
		side_t                  side_s;

		// rotate toward the x axis by the sign of y
		always_comb begin
			dx = cy_chain[i] >>> i;
			dy = cx_chain[i] >>> i;
			if (!cy_chain[i][CX_W-1]) begin
				cx_nx = cx_chain[i] + dx;
				cy_nx = cy_chain[i] - dy;
				z_nx = z_chain[i] + ATAN_I;
			end else begin
				cx_nx = cx_chain[i] - dx;
				cy_nx = cy_chain[i] + dy;
				z_nx = z_chain[i] - ATAN_I;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s <= 1'b0;
			end else if (en) begin
				valid_s <= valid_chain[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cx_s <= cx_nx;
				cy_s <= cy_nx;
				z_s <= z_nx;
				side_s <= side_chain[i];
			end
		end

		assign valid_chain[i+1] = valid_s;
		assign cx_chain[i+1] = cx_s;
		assign cy_chain[i+1] = cy_s;
		assign z_chain[i+1] = z_s;
		assign side_chain[i+1] = side_s;
	end

	assign cordic_valid = valid_chain[CORDIC_STEPS];
	assign cx_out = cx_chain[CORDIC_STEPS];
	assign z_out = z_chain[CORDIC_STEPS];
	assign side_out = side_chain[CORDIC_STEPS];

endmodule

>>> design/c2p_post.sv
// back end: angle rounding and unfolding, gain correction, denormalize, result register
// depends on c2p_pkg

module c2p_post (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 valid,
	input  logic signed [c2p_pkg::CX_W-1:0]      cx,
	input  logic signed [c2p_pkg::Z_W-1:0]       z,
	input  c2p_pkg::side_t                       side,
	output logic                                 res_valid,
	output logic [c2p_pkg::MAG_W-1:0]            magnitude,
	output logic signed [c2p_pkg::ANGLE_W-1:0]   angle,
	output logic [c2p_pkg::QUAD_W-1:0]           quadrant
);
	import c2p_pkg::*;

	localparam int XF_W = CX_W - 1;
	localparam int ZC_W = 31;
	localparam int PH_W = XF_W - 16 + 32;
	localparam int PL_W = 48;
	localparam logic [ZC_W-1:0] Z_LIM = ZC_W'(1 << 30);

	logic [ZC_W-1:0]          zc;
	logic [ZC_W-1:0]          zr;
	logic [A_W-1:0]           a_d;
	logic [XF_W-1:0]          xf;
	logic [XF_W-17:0]         xf_hi;
	logic [15:0]              xf_lo;

	logic                     valid_s1;
	logic [PH_W-1:0]          prod_hi_s1;
	logic [PL_W-1:0]          prod_lo_s1;
	logic [A_W-1:0]           a_s1;
	side_t                    side_s1;

	logic [SUM_W-1:0]         rnd;
	logic signed [ANGLE_W-1:0] base;
	logic signed [ANGLE_W-1:0] theta;

	logic                     valid_s2;
	logic [SUM_W-1:0]         sum_s2;
	logic signed [ANGLE_W-1:0] theta_s2;
	side_t                    side_s2;

	logic [SUM_W-1:0]         mfull;
	logic [MAG_W-1:0]         mag_d;

	logic                     valid_s3;
	logic [MAG_W-1:0]         mag_s3;
	logic signed [ANGLE_W-1:0] angle_s3;
	logic [QUAD_W-1:0]        quad_s3;

	// clamp angle to a quarter turn, round to output units, gain products
	always_comb begin
		if (z[Z_W-1]) begin
			zc = '0;
		end else if (ZC_W'(z) > Z_LIM || z[Z_W-2]) begin
			zc = Z_LIM;
		end else begin
			zc = ZC_W'(z);
		end
		zr = zc + ZC_W'(1 << 15);
		case (side.kind)
			KIND_GENERAL: a_d = zr[ZC_W-1:16];
			KIND_Y_AXIS:  a_d = A_W'(HALF_PI_OUT);
			default:      a_d = '0;
		endcase
		xf = cx[CX_W-1] ? '0 : cx[XF_W-1:0];
		xf_hi = xf[XF_W-1:16];
		xf_lo = xf[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_hi_s1 <= PH_W'(xf_hi) * PH_W'(GAIN_Q32);
			prod_lo_s1 <= PL_W'(xf_lo) * PL_W'(GAIN_Q32);
			a_s1 <= a_d;
			side_s1 <= side;
		end
	end

	// sum the gain products with the rounding bit; unfold the angle
	always_comb begin
		rnd = SUM_W'(1) << (7'd15 + 7'(side_s1.sh));
		base = side_s1.x_neg ? (ANGLE_W'(PI_OUT) - ANGLE_W'(a_s1)) : ANGLE_W'(a_s1);
		theta = side_s1.y_neg ? -base : base;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= SUM_W'(prod_hi_s1) + SUM_W'(prod_lo_s1[PL_W-1:16]) + rnd;
			theta_s2 <= theta;
			side_s2 <= side_s1;
		end
	end

	// denormalize, saturate and pick by point class
	always_comb begin
		mfull = sum_s2 >> (7'd16 + 7'(side_s2.sh));
		case (side_s2.kind)
			KIND_GENERAL: mag_d = (mfull[SUM_W-1:MAG_W] != '0) ? '1 : mfull[MAG_W-1:0];
			KIND_X_AXIS,
			KIND_Y_AXIS:  mag_d = side_s2.axis_mag;
			default:      mag_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s3 <= mag_d;
			angle_s3 <= theta_s2;
			quad_s3 <= side_s2.quad;
		end
	end

	assign res_valid = valid_s3;
	assign magnitude = mag_s3;
	assign angle = angle_s3;
	assign quadrant = quad_s3;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// self-checking bench for cartesian_to_polar: random idling on both channels,
// every accepted point is predicted in fixed point and matched to the result words
// depends on c2p_pkg and cartesian_to_polar from the design folder

module tb_top;
	import c2p_pkg::*;

	localparam int COORD_WIDTH = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = CORDIC_STEPS + 16;

	// cordic fixed point formats
	localparam int NORM_BIT = 39;
	localparam longint unsigned FOLD_GAIN = 64'h9B74EDA8;
	localparam longint ANGLE_HALF_PI = 16384;
	localparam longint ANGLE_PI = 32768;
	localparam longint Z_CLAMP = 64'd1 << 30;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct packed {
		coord_t              x;
		coord_t              y;
		logic [MAG_W-1:0]    mag;
		logic [ANGLE_W-1:0]  ang;
		logic [QUAD_W-1:0]   quad;
	} polar_rec_t;

	// arctangent of 2^-i in units of pi/2^31
	longint atan_lut [0:31] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
		81, 41, 20, 10, 5, 3, 1, 1, 0
	};

	logic                clk;
	logic                arst_n = 1'b0;
	logic                pt_valid = 1'b0;
	logic                pt_ready;
	coord_t              x_coord = '0;
	coord_t              y_coord = '0;
	logic                res_valid;
	logic                res_ready = 1'b0;
	logic [MAG_W-1:0]    magnitude;
	logic signed [ANGLE_W-1:0] angle;
	logic [QUAD_W-1:0]   quadrant;

	polar_rec_t expected_polar [$];
	int error_count = 0;
	int cycle_count = 0;
	int stall_left = 0;
	bit gaps_on = 1'b0;

	cartesian_to_polar #(
		.COORD_WIDTH(COORD_WIDTH),
		.CORDIC_STEPS(CORDIC_STEPS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pt_valid(pt_valid),
		.pt_ready(pt_ready),
		.x_coord(x_coord),
		.y_coord(y_coord),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.magnitude(magnitude),
		.angle(angle),
		.quadrant(quadrant)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("Some tests failed");
			$finish;
		end
	end

	// polar form of one point: fold, normalize, vector onto the x axis, unfold
	function automatic polar_rec_t polar_of_point(input coord_t xv, input coord_t yv);
		longint xs, ys, cx, cy, dx, dy, z, ang, theta;
		longint unsigned ax, ay, m, xf, total, mag;
		int sh, i;
		logic [QUAD_W-1:0] q;
		polar_rec_t r;
		xs = xv;
		ys = yv;
		ax = (xs < 0) ? -xs : xs;
		ay = (ys < 0) ? -ys : ys;

		// quadrant code, axes follow their own rule
		if (xs > 0)
			q = (ys >= 0) ? QUAD_1 : QUAD_4;
		else if (xs < 0)
			q = (ys > 0) ? QUAD_2 : QUAD_3;
		else
			q = (ys > 0) ? QUAD_2 : ((ys < 0) ? QUAD_4 : QUAD_ORIGIN);

		if (ax == 0 && ay == 0) begin
			mag = 0;
			ang = 0;
		end else if (ay == 0) begin
			mag = ax;
			ang = 0;
		end else if (ax == 0) begin
			mag = ay;
			ang = ANGLE_HALF_PI;
		end else begin
			// larger coordinate into [2^39, 2^40)
			m = (ax > ay) ? ax : ay;
			sh = 0;
			while (m < (64'd1 << NORM_BIT) && sh < 60) begin
				m = m << 1;
				sh++;
			end
			cx = longint'(ax << sh);
			cy = longint'(ay << sh);
			z = 0;
			// micro-rotations, shifts round toward minus infinity
			for (i = 0; i < CORDIC_STEPS && i < 32; i++) begin
				dx = cy >>> i;
				dy = cx >>> i;
				if (cy >= 0) begin
					cx = cx + dx;
					cy = cy - dy;
					z = z + atan_lut[i];
				end else begin
					cx = cx - dx;
					cy = cy + dy;
					z = z - atan_lut[i];
				end
			end
			if (z < 0)
				z = 0;
			if (z > Z_CLAMP)
				z = Z_CLAMP;
			ang = (z + 32768) >>> 16;
			// gain correction and rounding back to input units
			xf = (cx < 0) ? 64'd0 : longint'(cx);
			total = (xf >> 16) * FOLD_GAIN + (((xf & 64'hFFFF) * FOLD_GAIN) >> 16);
			mag = (total + (64'd1 << (sh + 15))) >> (sh + 16);
		end

		theta = (xs < 0) ? (ANGLE_PI - ang) : ang;
		if (ys < 0)
			theta = -theta;
		if (mag > MAG_MAX)
			mag = MAG_MAX;

		r.x = xv;
		r.y = yv;
		r.mag = mag[MAG_W-1:0];
		r.ang = theta[ANGLE_W-1:0];
		r.quad = q;
		return r;
	endfunction

	// idle length: mostly none, some short, a few long
	function automatic int idle_gap();
		int roll;
		if (!gaps_on)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// signed value in [-span, span-1]
	function automatic coord_t rand_coord(input int span);
		int v;
		v = int'($urandom_range(0, 2 * span - 1)) - span;
		return v[COORD_WIDTH-1:0];
	endfunction

	// result side stalls
	always @(posedge clk) begin
		if (stall_left > 0) begin
			res_ready <= 1'b0;
			stall_left = stall_left - 1;
		end else begin
			res_ready <= 1'b1;
			stall_left = idle_gap();
		end
	end

	// scoreboard: check each result word, then queue the prediction for each point
	always @(posedge clk) begin : check_words
		polar_rec_t want;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (expected_polar.size() == 0) begin
					$display("%0t: result with none expected, mag %0d angle %0d quad %0d",
						$time, magnitude, angle, quadrant);
					error_count++;
				end else begin
					want = expected_polar.pop_front();
					if (magnitude !== want.mag) begin
						$display("%0t: (%0d,%0d) magnitude expected %0d actual %0d",
							$time, want.x, want.y, want.mag, magnitude);
						error_count++;
					end
					if (angle !== want.ang) begin
						$display("%0t: (%0d,%0d) angle expected %0d actual %0d",
							$time, want.x, want.y, $signed(want.ang), angle);
						error_count++;
					end
					if (quadrant !== want.quad) begin
						$display("%0t: (%0d,%0d) quadrant expected %0d actual %0d",
							$time, want.x, want.y, want.quad, quadrant);
						error_count++;
					end
				end
			end
			if (pt_valid && pt_ready)
				expected_polar.push_back(polar_of_point(x_coord, y_coord));
		end
	end

	// present one point and hold it until taken; called at a rising edge
	task automatic send_point(input coord_t xv, input coord_t yv);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			pt_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pt_valid <= 1'b1;
		x_coord <= xv;
		y_coord <= yv;
		do @(posedge clk); while (!pt_ready);
	endtask

	// same as send_point for integer coordinates
	task automatic send_xy(input int xv, input int yv);
		send_point(xv[COORD_WIDTH-1:0], yv[COORD_WIDTH-1:0]);
	endtask

	// origin, both axes, extreme corners, and the angle that rounds to pi below the axis
	task automatic test_special_points();
		gaps_on = 1'b0;
		send_xy(0, 0);
		send_xy(32767, 0);
		send_xy(-32768, 0);
		send_xy(0, 32767);
		send_xy(0, -32768);
		send_xy(1, 0);
		send_xy(-1, 0);
		send_xy(0, 1);
		send_xy(0, -1);
		send_xy(32767, 32767);
		send_xy(-32768, -32768);
		send_xy(-32768, 32767);
		send_xy(32767, -32768);
		send_xy(1, 1);
		send_xy(-1, -1);
		send_xy(1, -1);
		send_xy(-1, 1);
		send_xy(-32768, -1);
		send_xy(-32768, 1);
		send_xy(32767, 1);
		send_xy(1, 32767);
		send_xy(3, 4);
		send_xy(-3, -4);
	endtask

	// whole input range with idling on both sides
	task automatic test_random_full();
		gaps_on = 1'b1;
		repeat (250)
			send_point(rand_coord(32768), rand_coord(32768));
	endtask

	// tiny points, deep normalization shifts
	task automatic test_random_small();
		gaps_on = 1'b1;
		repeat (150)
			send_point(rand_coord(16), rand_coord(16));
	endtask

	// one coordinate near zero: axis and near axis angles, rounding near 0 and pi
	task automatic test_near_axis();
		coord_t big, tiny;
		gaps_on = 1'b1;
		repeat (150) begin
			big = rand_coord(32768);
			tiny = rand_coord(4);
			if ($urandom_range(0, 1))
				send_point(big, tiny);
			else
				send_point(tiny, big);
		end
	endtask

	// back to back words with no idling anywhere
	task automatic test_burst();
		gaps_on = 1'b0;
		repeat (50)
			send_point(rand_coord(32768), rand_coord(32768));
	endtask

	// sequence
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_points();
		test_random_full();
		test_random_small();
		test_near_axis();
		test_burst();
		pt_valid <= 1'b0;
		gaps_on = 1'b1;
		while (expected_polar.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
